/* rtl/psg_pkg.sv */
`default_nettype none
// shared types, constants and the attenuation level table for the sound generator
// no dependencies
package psg_pkg;

  localparam int PEAK_LEVEL = 8191;
  localparam int LEVEL_W    = $clog2(PEAK_LEVEL + 1);
  localparam int SAMPLE_W   = 16;
  localparam int NUM_CH     = 4;
  localparam int PERIOD_W   = 10;
  localparam int SHIFT_W    = 16;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0]          NOISE_CH     = 2'd3;
  localparam logic [1:0]          RATE_TONE2   = 2'd3;
  localparam logic [PERIOD_W-1:0] NOISE_BASE   = 10'h010;
  localparam logic [SHIFT_W-1:0]  SHIFT_SEED   = 16'h8000;
  localparam logic [SHIFT_W-1:0]  TAP_MASK_RST = 16'h0009;
  localparam logic [3:0]          ATTEN_SILENT = 4'hf;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_SET_ATTEN,
    OP_NOISE_CTRL,
    OP_TONE_LOW,
    OP_TONE_HIGH
  } op_t;

  // one classified command from front to back
  typedef struct packed {
    op_t        op;
    logic [1:0] ch;
    logic [5:0] data;
  } cmd_t;

  typedef logic [LEVEL_W-1:0] level_tbl_t [16];

  // 2 dB steps, rounded half up, last entry silent
  function automatic level_tbl_t build_level_table();
    level_tbl_t  t;
    logic [31:0] v;
    v = 32'(PEAK_LEVEL);
    for (int i = 0; i < 15; i++) begin
      t[i] = LEVEL_W'(v);
      v = (v * 32'd52057 + 32'd32768) >> 16;
    end
    t[15] = '0;
    return t;
  endfunction

  localparam level_tbl_t LEVEL_TABLE = build_level_table();

endpackage
`default_nettype wire

/* rtl/psg_tone_noise_generator.sv */
`default_nettype none
// top level of the four-channel tone and noise generator
// instantiates psg_front, psg_cmd_queue and psg_back; uses psg_pkg
//
// usage:
//   input channel (in_valid / in_ready): one beat is either a register write
//   byte (in_mode = 0, in_data_byte holds the byte) or one tick of the divided
//   chip clock (in_mode = 1, in_data_byte ignored)
//   result channel (out_valid / out_ready): exactly one beat per input beat,
//   out_mixed_sample is the signed sum of the four channel levels after it
//   config port: cfg_wr_en with cfg_wr_data writes the white noise tap mask
//   in the same cycle, write it only while the block is idle
// result path: an accepted input beat is written into the command queue, and
//   the back end then registers its result into the output register
// throughput: one beat per cycle while out_ready stays high, set by the
//   channel update in the back end
// reset (rst_n low, synchronous): all channels silent, periods and counters
//   zero, noise shift register 0x8000, tap mask 0x0009, queue emptied
// receiver stall: the output register holds its beat, the back end stops,
//   the two-entry command queue keeps taking beats until full, then in_ready
//   drops until out_ready returns
module psg_tone_noise_generator (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_mode,
  input  wire logic [7:0]                     in_data_byte,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [psg_pkg::SAMPLE_W-1:0] out_mixed_sample,
  input  wire logic                           cfg_wr_en,
  input  wire logic [15:0]                    cfg_wr_data
);
  import psg_pkg::*;

  // front to queue
  cmd_t front_cmd;
  logic front_valid;
  logic front_ready;

  // queue to back
  cmd_t back_cmd;
  logic back_valid;
  logic back_ready;

  // classify write bytes against the latched channel and type
  psg_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_data_byte (in_data_byte),
    .cmd_valid    (front_valid),
    .cmd_ready    (front_ready),
    .cmd          (front_cmd)
  );

  // decouples input acceptance from output stalls
  psg_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_cmd   (front_cmd),
    .rd_valid (back_valid),
    .rd_ready (back_ready),
    .rd_cmd   (back_cmd)
  );

  // channel state, mixing and the output register
  psg_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (back_valid),
    .cmd_ready        (back_ready),
    .cmd              (back_cmd),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_mixed_sample (out_mixed_sample)
  );

endmodule
`default_nettype wire

/* rtl/psg_front.sv */
`default_nettype none
// front end: accepts input beats, tracks the latched channel and type,
// classifies each beat into a command; uses psg_pkg
module psg_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          in_mode,
  input  wire logic [7:0]    in_data_byte,
  output logic               cmd_valid,
  input  wire logic          cmd_ready,
  output psg_pkg::cmd_t      cmd
);
  import psg_pkg::*;

  logic [1:0] latched_ch_r, latched_ch_nxt;
  logic       latched_vol_r, latched_vol_nxt;
  logic       is_latch;
  logic       push;

  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;
  assign push      = in_valid && cmd_ready;
  assign is_latch  = !in_mode && in_data_byte[7];

  always_comb begin
    latched_ch_nxt  = latched_ch_r;
    latched_vol_nxt = latched_vol_r;
    if (is_latch) begin
      latched_ch_nxt  = in_data_byte[6:5];
      latched_vol_nxt = in_data_byte[4];
    end

    cmd.ch   = latched_ch_nxt;
    cmd.data = in_data_byte[5:0];
    if (in_mode) begin
      cmd.op = OP_TICK;
    end else if (latched_vol_nxt) begin
      cmd.op = OP_SET_ATTEN;
    end else if (is_latch && latched_ch_nxt == NOISE_CH) begin
      cmd.op = OP_NOISE_CTRL;
    end else if (is_latch) begin
      cmd.op = OP_TONE_LOW;
    end else begin
      cmd.op = OP_TONE_HIGH;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latched_ch_r  <= '0;
      latched_vol_r <= 1'b0;
    end else if (push) begin
      latched_ch_r  <= latched_ch_nxt;
      latched_vol_r <= latched_vol_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/psg_cmd_queue.sv */
`default_nettype none
// short command queue between front and back
// uses psg_pkg for the command type and depth
module psg_cmd_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  input  wire psg_pkg::cmd_t wr_cmd,
  output logic               rd_valid,
  input  wire logic          rd_ready,
  output psg_pkg::cmd_t      rd_cmd
);
  import psg_pkg::*;

  cmd_t                entry_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CW-1:0] count_r, count_nxt;
  logic                push, pop;

  assign wr_ready = count_r != QUEUE_CW'(QUEUE_DEPTH);
  assign rd_valid = count_r != '0;
  assign rd_cmd   = entry_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule
`default_nettype wire

/* rtl/psg_back.sv */
`default_nettype none
// back end: channel state, tick processing, level mixing and output register
// uses psg_pkg for the command type and the level table
module psg_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cmd_valid,
  output logic                            cmd_ready,
  input  wire psg_pkg::cmd_t              cmd,
  input  wire logic                       cfg_wr_en,
  input  wire logic [15:0]                cfg_wr_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [psg_pkg::SAMPLE_W-1:0] out_mixed_sample
);
  import psg_pkg::*;

  logic [PERIOD_W-1:0] period_r [NUM_CH];
  logic [PERIOD_W-1:0] period_nxt [NUM_CH];
  logic [PERIOD_W-1:0] cnt_r [NUM_CH];
  logic [PERIOD_W-1:0] cnt_nxt [NUM_CH];
  logic [PERIOD_W-1:0] dec [NUM_CH];
  logic [NUM_CH-1:0]   pol_r, pol_nxt;
  logic [3:0]          atten_r [NUM_CH];
  logic [3:0]          atten_nxt [NUM_CH];
  logic [SHIFT_W-1:0]  shift_r, shift_nxt;
  logic [SHIFT_W-1:0]  tap_mask_r;
  logic                fb;
  logic                fire;
  logic                out_valid_r;
  logic signed [SAMPLE_W-1:0] sample_r, sum_nxt;
  logic signed [SAMPLE_W-1:0] lv;

  assign cmd_ready        = !out_valid_r || out_ready;
  assign fire             = cmd_valid && cmd_ready;
  assign out_valid        = out_valid_r;
  assign out_mixed_sample = sample_r;

  always_comb begin
    period_nxt = period_r;
    cnt_nxt    = cnt_r;
    pol_nxt    = pol_r;
    atten_nxt  = atten_r;
    shift_nxt  = shift_r;
    fb         = 1'b0;
    for (int i = 0; i < NUM_CH; i++) begin
      dec[i] = cnt_r[i] - 1'b1;
    end

    unique case (cmd.op)
      OP_TICK: begin
        for (int i = 0; i < NUM_CH - 1; i++) begin
          cnt_nxt[i] = dec[i];
          if (dec[i] == '0) begin
            cnt_nxt[i] = period_r[i];
            pol_nxt[i] = !pol_r[i];
          end
        end
        cnt_nxt[NOISE_CH] = dec[NOISE_CH];
        if (dec[NOISE_CH] == '0) begin
          // noise reload: fixed rates or follow tone 2
          if (period_r[NOISE_CH][1:0] == RATE_TONE2) begin
            cnt_nxt[NOISE_CH] = period_r[2];
          end else begin
            cnt_nxt[NOISE_CH] = NOISE_BASE << period_r[NOISE_CH][1:0];
          end
          fb = period_r[NOISE_CH][2] ? ^(shift_r & tap_mask_r) : shift_r[0];
          shift_nxt = {fb, shift_r[SHIFT_W-1:1]};
          pol_nxt[NOISE_CH] = shift_nxt[0];
        end
      end
      OP_SET_ATTEN: begin
        atten_nxt[cmd.ch] = cmd.data[3:0];
      end
      OP_NOISE_CTRL: begin
        period_nxt[NOISE_CH] = {7'b0, cmd.data[2:0]};
        shift_nxt            = SHIFT_SEED;
      end
      OP_TONE_LOW: begin
        period_nxt[cmd.ch] = {period_r[cmd.ch][PERIOD_W-1:4], cmd.data[3:0]};
      end
      OP_TONE_HIGH: begin
        period_nxt[cmd.ch] = {cmd.data, period_r[cmd.ch][3:0]};
        cnt_nxt[cmd.ch]    = {cmd.data, period_r[cmd.ch][3:0]};
      end
      default: begin
      end
    endcase
  end

  // mix of the four channels after this command
  always_comb begin
    sum_nxt = '0;
    lv      = '0;
    for (int i = 0; i < NUM_CH; i++) begin
      lv = $signed(SAMPLE_W'(LEVEL_TABLE[atten_nxt[i]]));
      sum_nxt = pol_nxt[i] ? sum_nxt + lv : sum_nxt - lv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CH; i++) begin
        period_r[i] <= '0;
        cnt_r[i]    <= '0;
        atten_r[i]  <= ATTEN_SILENT;
      end
      pol_r       <= '0;
      shift_r     <= SHIFT_SEED;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        period_r    <= period_nxt;
        cnt_r       <= cnt_nxt;
        atten_r     <= atten_nxt;
        pol_r       <= pol_nxt;
        shift_r     <= shift_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_mask_r <= TAP_MASK_RST;
    end else if (cfg_wr_en) begin
      tap_mask_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      sample_r <= sum_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/psg_checker.sv */
`default_nettype none
// port-level checks for the tone and noise generator, bound to the top level
// uses psg_pkg for the sample width
module psg_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic signed [psg_pkg::SAMPLE_W-1:0] out_mixed_sample
);
  import psg_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mixed_sample))
    else $error("result beat changed while stalled");

  // no result beat right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // mix stays within four peak levels
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_mixed_sample >= -16'sd32764) && (out_mixed_sample <= 16'sd32764))
    else $error("mixed sample out of range");

  // a new result beat follows an earlier accepted input beat
  a_rise_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result beat without an input beat");

endmodule

bind psg_tone_noise_generator psg_checker u_psg_checker (.*);
`default_nettype wire
